// ===== sv/lle_pkg.sv =====
// Package for the bounded linked list engine: sizes, codes and the structs
// passed between the sequencer, the node store and the free map.
// No dependencies.
package lle_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LINK_W   = 7;
   localparam int DATA_W   = 32;
   localparam int COUNT_W  = 7;
   localparam int OP_W     = 3;
   localparam int STATUS_W = 2;

   // All ones in a link means "no next node".
   localparam logic [LINK_W-1:0] NULL_LINK = '1;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_INS_AFTER  = 3'd1,
      OP_PUSH_BACK  = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_DEL_KEY    = 3'd4,
      OP_POP_BACK   = 3'd5,
      OP_SEARCH     = 3'd6,
      OP_TRAVERSE   = 3'd7
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_EMPTY     = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_WALK,
      ST_LINK
   } state_type;

   typedef struct packed {
      logic                     val_en;
      logic                     link_en;
      logic [IDX_W-1:0]         addr;
      logic signed [DATA_W-1:0] val;
      logic [LINK_W-1:0]        link;
   } node_wr_type;

   typedef struct packed {
      logic             alloc;
      logic             release_en;
      logic [IDX_W-1:0] release_idx;
   } free_cmd_type;

endpackage

// ===== sv/lle_node_store.sv =====
// Node store: value and link memories, one write and one read address per cycle.
// Read data is registered. Depends on lle_pkg.
module lle_node_store (
   input  logic                              clock,
   input  lle_pkg::node_wr_type              node_wr,
   input  logic [lle_pkg::IDX_W-1:0]         rd_addr,
   output logic signed [lle_pkg::DATA_W-1:0] rd_val_ff,
   output logic [lle_pkg::LINK_W-1:0]        rd_link_ff
);
   import lle_pkg::*;

   logic signed [DATA_W-1:0] value_mem [CAPACITY];
   logic [LINK_W-1:0]        link_mem  [CAPACITY];

   always_ff @(posedge clock) begin
      if (node_wr.val_en) begin
         value_mem[node_wr.addr] <= node_wr.val;
      end
      if (node_wr.link_en) begin
         link_mem[node_wr.addr] <= node_wr.link;
      end
      rd_val_ff  <= value_mem[rd_addr];
      rd_link_ff <= link_mem[rd_addr];
   end

endmodule

// ===== sv/lle_free_map.sv =====
// Free map of the node store with a registered lowest-free-index finder.
// Depends on lle_pkg.
module lle_free_map (
   input  logic                      clock,
   input  logic                      reset,
   input  lle_pkg::free_cmd_type     free_cmd,
   output logic                      free_any_ff,
   output logic [lle_pkg::IDX_W-1:0] free_idx_ff
);
   import lle_pkg::*;

   logic [CAPACITY-1:0] free_map_ff, free_map_in;
   logic [CAPACITY-1:0] lowest_bit;
   logic [IDX_W-1:0]    lowest_idx;

   always_comb begin
      free_map_in = free_map_ff;
      if (free_cmd.alloc) begin
         free_map_in[free_idx_ff] = 1'b0;
      end
      if (free_cmd.release_en) begin
         free_map_in[free_cmd.release_idx] = 1'b1;
      end
   end

   // Isolate the lowest set bit, then encode the resulting one-hot word.
   always_comb begin
      lowest_bit = free_map_ff & (~free_map_ff + CAPACITY'(1));
      lowest_idx = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (lowest_bit[i]) begin
            lowest_idx = lowest_idx | IDX_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_map_ff <= '1;
         free_any_ff <= 1'b1;
         free_idx_ff <= '0;
      end else begin
         free_map_ff <= free_map_in;
         free_any_ff <= |free_map_ff;
         free_idx_ff <= lowest_idx;
      end
   end

endmodule

// ===== sv/lle_ctrl.sv =====
// Sequencer: takes one request, walks the list one node read per cycle while not
// stalled and updates head, count, sum and response register. Depends on lle_pkg.
module lle_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [lle_pkg::OP_W-1:0]          req_operation,
   input  logic signed [lle_pkg::DATA_W-1:0] req_key,
   input  logic signed [lle_pkg::DATA_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [lle_pkg::STATUS_W-1:0]      rsp_status,
   output logic signed [lle_pkg::DATA_W-1:0] rsp_element,
   output logic [lle_pkg::COUNT_W-1:0]       rsp_entry_count,
   output logic signed [lle_pkg::DATA_W-1:0] rsp_total_sum,
   output logic                              rsp_last,
   output lle_pkg::node_wr_type              node_wr,
   output logic [lle_pkg::IDX_W-1:0]         rd_addr,
   input  logic signed [lle_pkg::DATA_W-1:0] rd_val,
   input  logic [lle_pkg::LINK_W-1:0]        rd_link,
   output lle_pkg::free_cmd_type             free_cmd,
   input  logic                              free_any,
   input  logic [lle_pkg::IDX_W-1:0]         free_idx
);
   import lle_pkg::*;

   state_type                state_ff, state_in;
   op_type                   op_ff, op_in;
   logic signed [DATA_W-1:0] key_ff, key_in;
   logic signed [DATA_W-1:0] value_ff, value_in;
   logic [IDX_W-1:0]         cur_ff, cur_in;
   logic [LINK_W-1:0]        prev_ff, prev_in;
   logic [IDX_W-1:0]         new_ff, new_in;
   logic [LINK_W-1:0]        head_ff, head_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic signed [DATA_W-1:0] sum_ff, sum_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic signed [DATA_W-1:0] rsp_element_ff, rsp_element_in;
   logic [COUNT_W-1:0]       rsp_count_ff, rsp_count_in;
   logic signed [DATA_W-1:0] rsp_sum_ff, rsp_sum_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     out_free;
   logic                     emit;
   status_type               e_status;
   logic signed [DATA_W-1:0] e_elem;
   logic                     e_last;
   logic                     head_is_node;
   logic                     link_is_node;
   logic                     key_hit;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign head_is_node = head_ff < LINK_W'(CAPACITY);
   assign link_is_node = rd_link < LINK_W'(CAPACITY);
   assign key_hit      = rd_val == key_ff;
   assign req_stall    = state_ff != ST_IDLE;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      key_in   = key_ff;
      value_in = value_ff;
      cur_in   = cur_ff;
      prev_in  = prev_ff;
      new_in   = new_ff;
      head_in  = head_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      node_wr  = '0;
      free_cmd = '0;
      rd_addr  = cur_ff;
      emit     = 1'b0;
      e_status = STATUS_OK;
      e_elem   = '0;
      e_last   = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = op_type'(req_operation);
               key_in   = req_key;
               value_in = req_value;
               state_in = ST_START;
            end
         end

         ST_START: begin
            if (op_ff == OP_PUSH_FRONT ||
                (op_ff == OP_PUSH_BACK && (!free_any || !head_is_node))) begin
               // Decided without reading the store.
               if (out_free) begin
                  emit     = 1'b1;
                  state_in = ST_IDLE;
                  if (!free_any) begin
                     e_status = STATUS_FULL;
                  end else begin
                     node_wr.val_en  = 1'b1;
                     node_wr.link_en = 1'b1;
                     node_wr.addr    = free_idx;
                     node_wr.val     = value_ff;
                     node_wr.link    = (op_ff == OP_PUSH_FRONT) ? head_ff : NULL_LINK;
                     free_cmd.alloc  = 1'b1;
                     head_in         = LINK_W'(free_idx);
                     count_in        = count_ff + COUNT_W'(1);
                     sum_in          = sum_ff + value_ff;
                     e_elem          = value_ff;
                  end
               end
            end else if (!head_is_node) begin
               if (out_free) begin
                  emit     = 1'b1;
                  state_in = ST_IDLE;
                  if (op_ff == OP_INS_AFTER || op_ff == OP_DEL_KEY ||
                      op_ff == OP_SEARCH) begin
                     e_status = STATUS_NOT_FOUND;
                  end else begin
                     e_status = STATUS_EMPTY;
                  end
               end
            end else begin
               rd_addr  = head_ff[IDX_W-1:0];
               cur_in   = head_ff[IDX_W-1:0];
               prev_in  = NULL_LINK;
               state_in = ST_WALK;
            end
         end

         ST_WALK: begin
            // rd_val and rd_link belong to node cur_ff. Holding re-reads it.
            case (op_ff)
               OP_POP_FRONT: begin
                  if (out_free) begin
                     emit                 = 1'b1;
                     e_elem               = rd_val;
                     head_in              = rd_link;
                     free_cmd.release_en  = 1'b1;
                     free_cmd.release_idx = cur_ff;
                     count_in             = count_ff - COUNT_W'(1);
                     sum_in               = sum_ff - rd_val;
                     state_in             = ST_IDLE;
                  end
               end

               OP_TRAVERSE: begin
                  if (out_free) begin
                     emit   = 1'b1;
                     e_elem = rd_val;
                     e_last = !link_is_node;
                     if (link_is_node) begin
                        rd_addr = rd_link[IDX_W-1:0];
                        cur_in  = rd_link[IDX_W-1:0];
                     end else begin
                        state_in = ST_IDLE;
                     end
                  end
               end

               OP_PUSH_BACK, OP_POP_BACK: begin
                  if (link_is_node) begin
                     rd_addr = rd_link[IDX_W-1:0];
                     cur_in  = rd_link[IDX_W-1:0];
                     prev_in = LINK_W'(cur_ff);
                  end else if (out_free) begin
                     emit = 1'b1;
                     if (op_ff == OP_PUSH_BACK) begin
                        // Space was checked at the start; the tail link is fixed next.
                        node_wr.val_en  = 1'b1;
                        node_wr.link_en = 1'b1;
                        node_wr.addr    = free_idx;
                        node_wr.val     = value_ff;
                        node_wr.link    = NULL_LINK;
                        free_cmd.alloc  = 1'b1;
                        new_in          = free_idx;
                        count_in        = count_ff + COUNT_W'(1);
                        sum_in          = sum_ff + value_ff;
                        e_elem          = value_ff;
                        state_in        = ST_LINK;
                     end else begin
                        if (prev_ff < LINK_W'(CAPACITY)) begin
                           node_wr.link_en = 1'b1;
                           node_wr.addr    = prev_ff[IDX_W-1:0];
                           node_wr.link    = NULL_LINK;
                        end else begin
                           head_in = NULL_LINK;
                        end
                        free_cmd.release_en  = 1'b1;
                        free_cmd.release_idx = cur_ff;
                        count_in             = count_ff - COUNT_W'(1);
                        sum_in               = sum_ff - rd_val;
                        e_elem               = rd_val;
                        state_in             = ST_IDLE;
                     end
                  end
               end

               default: begin
                  // Insert after, delete key and search.
                  if (!key_hit && link_is_node) begin
                     rd_addr = rd_link[IDX_W-1:0];
                     cur_in  = rd_link[IDX_W-1:0];
                     prev_in = LINK_W'(cur_ff);
                  end else if (out_free) begin
                     emit     = 1'b1;
                     state_in = ST_IDLE;
                     if (!key_hit) begin
                        e_status = STATUS_NOT_FOUND;
                     end else if (op_ff == OP_SEARCH) begin
                        e_elem = rd_val;
                     end else if (op_ff == OP_DEL_KEY) begin
                        if (prev_ff < LINK_W'(CAPACITY)) begin
                           node_wr.link_en = 1'b1;
                           node_wr.addr    = prev_ff[IDX_W-1:0];
                           node_wr.link    = rd_link;
                        end else begin
                           head_in = rd_link;
                        end
                        free_cmd.release_en  = 1'b1;
                        free_cmd.release_idx = cur_ff;
                        count_in             = count_ff - COUNT_W'(1);
                        sum_in               = sum_ff - rd_val;
                        e_elem               = rd_val;
                     end else if (!free_any) begin
                        e_status = STATUS_FULL;
                     end else begin
                        node_wr.val_en  = 1'b1;
                        node_wr.link_en = 1'b1;
                        node_wr.addr    = free_idx;
                        node_wr.val     = value_ff;
                        node_wr.link    = rd_link;
                        free_cmd.alloc  = 1'b1;
                        new_in          = free_idx;
                        count_in        = count_ff + COUNT_W'(1);
                        sum_in          = sum_ff + value_ff;
                        e_elem          = value_ff;
                        state_in        = ST_LINK;
                     end
                  end
               end
            endcase
         end

         ST_LINK: begin
            // Second write of an insert: point the found node at the new one.
            node_wr.link_en = 1'b1;
            node_wr.addr    = cur_ff;
            node_wr.link    = LINK_W'(new_ff);
            state_in        = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_status_in  = rsp_status_ff;
      rsp_element_in = rsp_element_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_sum_in     = rsp_sum_ff;
      rsp_last_in    = rsp_last_ff;
      if (emit) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = e_status;
         rsp_element_in = e_elem;
         rsp_count_in   = count_in;
         rsp_sum_in     = sum_in;
         rsp_last_in    = e_last;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= NULL_LINK;
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      key_ff         <= key_in;
      value_ff       <= value_in;
      cur_ff         <= cur_in;
      prev_ff        <= prev_in;
      new_ff         <= new_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_element_ff <= rsp_element_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_sum_ff     <= rsp_sum_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_element     = rsp_element_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_total_sum   = rsp_sum_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ===== sv/bounded_linked_list_engine.sv =====
// Top level of the bounded linked list engine: sequencer, node store and free map.
// Depends on lle_pkg, lle_node_store, lle_free_map and lle_ctrl.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_stall   operation, key, value
//   rsp_      out        rsp_valid/rsp_stall   status, element, entry_count,
//                                              total_sum, last
//
// One request is worked on at a time. A request that needs no walk (push front,
// push back into a full or empty list, any other request on an empty list) is
// answered from the start state; otherwise the walk reads one node per cycle
// from the node store, then an insert after or push back writes the found node's link.
// Traverse delivers one response per cycle while rsp_stall is low.
// Reset empties the list at once; the node store needs no clearing.
// A stalled response holds a traverse at its current node, other walks at the node of their answer.
module bounded_linked_list_engine (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [lle_pkg::OP_W-1:0]          req_operation,
   input  logic signed [lle_pkg::DATA_W-1:0] req_key,
   input  logic signed [lle_pkg::DATA_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [lle_pkg::STATUS_W-1:0]      rsp_status,
   output logic signed [lle_pkg::DATA_W-1:0] rsp_element,
   output logic [lle_pkg::COUNT_W-1:0]       rsp_entry_count,
   output logic signed [lle_pkg::DATA_W-1:0] rsp_total_sum,
   output logic                              rsp_last
);
   import lle_pkg::*;

   node_wr_type              node_wr;
   logic [IDX_W-1:0]         rd_addr;
   logic signed [DATA_W-1:0] rd_val;
   logic [LINK_W-1:0]        rd_link;
   free_cmd_type             free_cmd;
   logic                     free_any;
   logic [IDX_W-1:0]         free_idx;

   lle_node_store u_node_store (
      .clock      (clock),
      .node_wr    (node_wr),
      .rd_addr    (rd_addr),
      .rd_val_ff  (rd_val),
      .rd_link_ff (rd_link)
   );

   lle_free_map u_free_map (
      .clock       (clock),
      .reset       (reset),
      .free_cmd    (free_cmd),
      .free_any_ff (free_any),
      .free_idx_ff (free_idx)
   );

   lle_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_key         (req_key),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_element     (rsp_element),
      .rsp_entry_count (rsp_entry_count),
      .rsp_total_sum   (rsp_total_sum),
      .rsp_last        (rsp_last),
      .node_wr         (node_wr),
      .rd_addr         (rd_addr),
      .rd_val          (rd_val),
      .rd_link         (rd_link),
      .free_cmd        (free_cmd),
      .free_any        (free_any),
      .free_idx        (free_idx)
   );

endmodule

// ===== dv/bounded_linked_list_engine_checker.sv =====
`timescale 1ns / 1ps
// Checker for the bounded linked list engine. It mirrors the list from the
// accepted requests and compares every response with the oldest awaited one.
// Depends on lle_pkg.
module bounded_linked_list_engine_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [lle_pkg::OP_W-1:0]          req_operation,
   input  logic signed [lle_pkg::DATA_W-1:0] req_key,
   input  logic signed [lle_pkg::DATA_W-1:0] req_value,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [lle_pkg::STATUS_W-1:0]      rsp_status,
   input  logic signed [lle_pkg::DATA_W-1:0] rsp_element,
   input  logic [lle_pkg::COUNT_W-1:0]       rsp_entry_count,
   input  logic signed [lle_pkg::DATA_W-1:0] rsp_total_sum,
   input  logic                              rsp_last,
   output int                                failures,
   output int                                outstanding
);
   import lle_pkg::*;

   typedef struct {
      status_type               status;
      logic signed [DATA_W-1:0] element;
      logic [COUNT_W-1:0]       entry_count;
      logic signed [DATA_W-1:0] total_sum;
      logic                     last;
   } list_answer_type;

   list_answer_type          awaited_answers[$];
   logic signed [DATA_W-1:0] shadow_entries[$];
   logic signed [DATA_W-1:0] shadow_sum;
   int                       response_number;

   // Count and sum are taken after the list has been updated.
   function automatic void post_answer(input status_type status,
                                       input logic signed [DATA_W-1:0] element,
                                       input logic last);
      list_answer_type answer;
      answer.status      = status;
      answer.element     = element;
      answer.entry_count = COUNT_W'(shadow_entries.size());
      answer.total_sum   = shadow_sum;
      answer.last        = last;
      awaited_answers.push_back(answer);
   endfunction

   function automatic void apply_list_op(input op_type op,
                                         input logic signed [DATA_W-1:0] key,
                                         input logic signed [DATA_W-1:0] value);
      int                       hit;
      logic signed [DATA_W-1:0] removed;
      hit = -1;
      foreach (shadow_entries[i]) begin
         if (hit < 0 && shadow_entries[i] == key) hit = i;
      end
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (shadow_entries.size() >= CAPACITY) begin
               post_answer(STATUS_FULL, '0, 1'b1);
            end else begin
               if (op == OP_PUSH_FRONT) shadow_entries.push_front(value);
               else shadow_entries.push_back(value);
               shadow_sum += value;
               post_answer(STATUS_OK, value, 1'b1);
            end
         end
         OP_INS_AFTER: begin
            // The key is looked for before the free space is considered.
            if (hit < 0) begin
               post_answer(STATUS_NOT_FOUND, '0, 1'b1);
            end else if (shadow_entries.size() >= CAPACITY) begin
               post_answer(STATUS_FULL, '0, 1'b1);
            end else begin
               shadow_entries.insert(hit + 1, value);
               shadow_sum += value;
               post_answer(STATUS_OK, value, 1'b1);
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (shadow_entries.size() == 0) begin
               post_answer(STATUS_EMPTY, '0, 1'b1);
            end else begin
               if (op == OP_POP_FRONT) removed = shadow_entries.pop_front();
               else removed = shadow_entries.pop_back();
               shadow_sum -= removed;
               post_answer(STATUS_OK, removed, 1'b1);
            end
         end
         OP_DEL_KEY: begin
            if (hit < 0) begin
               post_answer(STATUS_NOT_FOUND, '0, 1'b1);
            end else begin
               removed = shadow_entries[hit];
               shadow_entries.delete(hit);
               shadow_sum -= removed;
               post_answer(STATUS_OK, removed, 1'b1);
            end
         end
         OP_SEARCH: begin
            if (hit < 0) post_answer(STATUS_NOT_FOUND, '0, 1'b1);
            else post_answer(STATUS_OK, shadow_entries[hit], 1'b1);
         end
         default: begin
            if (shadow_entries.size() == 0) begin
               post_answer(STATUS_EMPTY, '0, 1'b1);
            end else begin
               foreach (shadow_entries[i]) begin
                  post_answer(STATUS_OK, shadow_entries[i], i == shadow_entries.size() - 1);
               end
            end
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at response %0d: %s", response_number, what);
      failures++;
   endtask

   always @(posedge clock) begin : watch
      list_answer_type want;
      if (reset) begin
         shadow_entries.delete();
         awaited_answers.delete();
         shadow_sum      = '0;
         response_number = 0;
      end else begin
         // A request is taken first, so that answers stay in their order.
         if (req_valid && !req_stall) begin
            apply_list_op(op_type'(req_operation), req_key, req_value);
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_answers.size() == 0) begin
               report_mismatch("response arrived with none awaited");
            end else begin
               want = awaited_answers.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, awaited %0d",
                                            rsp_status, want.status));
               if (rsp_element !== want.element)
                  report_mismatch($sformatf("element %0d, awaited %0d",
                                            rsp_element, want.element));
               if (rsp_entry_count !== want.entry_count)
                  report_mismatch($sformatf("entry count %0d, awaited %0d",
                                            rsp_entry_count, want.entry_count));
               if (rsp_total_sum !== want.total_sum)
                  report_mismatch($sformatf("total sum %0d, awaited %0d",
                                            rsp_total_sum, want.total_sum));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last %0b, awaited %0b",
                                            rsp_last, want.last));
            end
            response_number++;
         end
      end
      outstanding = awaited_answers.size();
   end

endmodule

// ===== dv/bounded_linked_list_engine_test.sv =====
`timescale 1ns / 1ps
// Testbench top for the bounded linked list engine: clock, reset, requests
// and response stalls, with the verdict taken from the checker beside the block.
// Depends on lle_pkg, bounded_linked_list_engine and its checker.
module bounded_linked_list_engine_test;
   import lle_pkg::*;

   localparam int CYCLE_LIMIT   = 1_500_000;
   localparam int SETTLE_CYCLES = 80;

   logic                     clock         = 1'b0;
   logic                     reset         = 1'b1;
   logic                     req_valid     = 1'b0;
   logic                     req_stall;
   logic [OP_W-1:0]          req_operation = '0;
   logic signed [DATA_W-1:0] req_key       = '0;
   logic signed [DATA_W-1:0] req_value     = '0;
   logic                     rsp_valid;
   logic                     rsp_stall     = 1'b0;
   logic [STATUS_W-1:0]      rsp_status;
   logic signed [DATA_W-1:0] rsp_element;
   logic [COUNT_W-1:0]       rsp_entry_count;
   logic signed [DATA_W-1:0] rsp_total_sum;
   logic                     rsp_last;

   int                       failures;
   int                       outstanding;
   int                       cycle_count = 0;
   bit                       calm = 1'b0;
   int                       gapless_left = 0;
   int                       stall_left = 0;
   int                       flow_left = 0;
   logic signed [DATA_W-1:0] value_pool[8];

   always #4 clock = ~clock;

   bounded_linked_list_engine DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_key         (req_key),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_element     (rsp_element),
      .rsp_entry_count (rsp_entry_count),
      .rsp_total_sum   (rsp_total_sum),
      .rsp_last        (rsp_last)
   );

   bounded_linked_list_engine_checker list_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_key         (req_key),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_element     (rsp_element),
      .rsp_entry_count (rsp_entry_count),
      .rsp_total_sum   (rsp_total_sum),
      .rsp_last        (rsp_last),
      .failures        (failures),
      .outstanding     (outstanding)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Response stalls alternate with free stretches, some of them long.
   always @(negedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (flow_left > 0) begin
         rsp_stall <= 1'b0;
         flow_left--;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = $urandom_range(1, 16);
         flow_left  = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 24);
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_request(input op_type op,
                               input logic signed [DATA_W-1:0] key,
                               input logic signed [DATA_W-1:0] value);
      int gap;
      gap = 0;
      if (!calm) begin
         if (gapless_left > 0) begin
            gapless_left--;
         end else begin
            gap          = $urandom_range(1, 16);
            gapless_left = $urandom_range(0, 12);
         end
      end
      repeat (gap) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_key       <= key;
      req_value     <= value;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic wait_until_quiet();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // Drawing from a small pool makes keys match entries often.
   function automatic logic signed [DATA_W-1:0] pool_or_random(input int pool_pct);
      if ($urandom_range(0, 99) < pool_pct) return value_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   task automatic run_phase(input int items, input int insert_pct, input int remove_pct);
      int     pick;
      op_type op;
      repeat (items) begin
         pick = $urandom_range(0, 99);
         if (pick < insert_pct)
            op = op_type'(OP_PUSH_FRONT + $urandom_range(0, 2));
         else if (pick < insert_pct + remove_pct)
            op = op_type'(OP_POP_FRONT + $urandom_range(0, 2));
         else
            op = ($urandom_range(0, 3) == 0) ? OP_TRAVERSE : OP_SEARCH;
         send_request(op, pool_or_random(80), pool_or_random(50));
      end
   endtask

   initial begin
      value_pool[0] = '0;
      value_pool[1] = -1;
      value_pool[2] = 32'sh7FFF_FFFF;
      value_pool[3] = 32'sh8000_0000;
      for (int i = 4; i < 8; i++) value_pool[i] = $urandom;

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Traverse, pops, search, delete key and insert after on the empty list first.
      send_request(OP_TRAVERSE, 0, 0);
      send_request(OP_POP_FRONT, 0, 0);
      send_request(OP_POP_BACK, 0, 0);
      send_request(OP_SEARCH, 0, 0);
      send_request(OP_DEL_KEY, 0, 0);
      send_request(OP_INS_AFTER, 0, 7);
      // Extreme values, so that the sum wraps both ways.
      send_request(OP_PUSH_FRONT, 0, 32'sh7FFF_FFFF);
      send_request(OP_PUSH_BACK, 0, 32'sh8000_0000);
      send_request(OP_PUSH_FRONT, 0, 0);
      send_request(OP_PUSH_BACK, 0, -1);
      send_request(OP_INS_AFTER, 32'sh7FFF_FFFF, 5);
      send_request(OP_INS_AFTER, 1234, 9);
      send_request(OP_SEARCH, 32'sh8000_0000, 0);
      send_request(OP_SEARCH, 77, 0);
      send_request(OP_TRAVERSE, 0, 0);
      send_request(OP_DEL_KEY, 0, 0);
      send_request(OP_DEL_KEY, -1, 0);
      send_request(OP_DEL_KEY, 4321, 0);
      send_request(OP_PUSH_BACK, 0, 32'sh7FFF_FFFF);
      // Two equal entries: only the first one is removed.
      send_request(OP_DEL_KEY, 32'sh7FFF_FFFF, 0);
      send_request(OP_TRAVERSE, 0, 0);
      send_request(OP_POP_FRONT, 0, 0);
      send_request(OP_POP_BACK, 0, 0);
      send_request(OP_TRAVERSE, 0, 0);

      run_phase(70, 40, 35);
      wait_until_quiet();
      // Mostly inserts, so the store fills and rejects further ones.
      run_phase(90, 90, 4);
      // Mostly removals, down to the empty list and past it.
      run_phase(80, 5, 85);
      calm = 1'b1;
      run_phase(36, 40, 35);
      wait_until_quiet();
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (failures == 0 && outstanding == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/lle_pkg.sv
sv/lle_node_store.sv
sv/lle_free_map.sv
sv/lle_ctrl.sv
sv/bounded_linked_list_engine.sv
dv/bounded_linked_list_engine_checker.sv
dv/bounded_linked_list_engine_test.sv
